FILE: rtl/uartfb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uartfb_pkg
// Types and constants shared by the UART FIFO bus device core and its testbench.
// ----------------------------------------------------------------------------
package uartfb_pkg;

  localparam int unsigned RxDepthDefault = 16;
  localparam int unsigned TxDepthDefault = 16;

  // transaction mode codes
  localparam logic [1:0] MODE_READ  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;

  // bus register offsets
  localparam logic [31:0] ADDR_DATA   = 32'd0;
  localparam logic [31:0] ADDR_STATUS = 32'd1;

  localparam logic [3:0] SIZE_BYTE = 4'd1;

  localparam logic [7:0] HALT_BYTE = 8'h17;  // control-W from the host

  localparam int unsigned STAT_RX_AVAIL_BIT = 0;
  localparam int unsigned STAT_TX_FULL_BIT  = 1;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] address;
    logic [3:0]  access_size;
    logic [7:0]  write_data;
    logic        host_valid;
    logic [7:0]  host_byte;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       access_error;
    logic       line_valid;
    logic [7:0] line_byte;
    logic       halt_request;
  } rsp_t;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_e;

endpackage

FILE: rtl/uart_fifo_bus_device_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_fifo_bus_device_core
// Bus-attached UART with receive and transmit ring FIFOs held in RAM.
// ----------------------------------------------------------------------------
// Result: the RAM read is registered at the accept edge, and the output register
//   is loaded from it in the read state once no held result is stalled.
// The input is stalled during the read state, so a new transaction waits for that RAM read.
// The next transaction is accepted while a finished result waits to be taken.
// Reset: FIFO pointers, state and valid flags clear; RAM contents are not reset.
module uart_fifo_bus_device_core
  import uartfb_pkg::*;
#(
  parameter int unsigned RxDepth = RxDepthDefault,
  parameter int unsigned TxDepth = TxDepthDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_data_o
);

  localparam int unsigned RxPw = $clog2(RxDepth);
  localparam int unsigned TxPw = $clog2(TxDepth);
  localparam logic [RxPw-1:0] RxLast = RxPw'(RxDepth - 1);
  localparam logic [TxPw-1:0] TxLast = TxPw'(TxDepth - 1);

  typedef struct packed {
    logic [7:0] status;
    logic       err;
    logic       halt;
    logic       rx_pop;
    logic       tx_drain;
  } pend_t;

  state_e state_q, state_d;
  logic [RxPw-1:0] rx_wr_q, rx_wr_d, rx_rd_q, rx_rd_d;
  logic [TxPw-1:0] tx_wr_q, tx_wr_d, tx_rd_q, tx_rd_d;
  pend_t pend_q, pend_d;
  rsp_t  out_q, out_d;
  logic  out_valid_q, out_valid_d;

  logic [RxPw-1:0] rx_wr_nxt, rx_rd_nxt;
  logic [TxPw-1:0] tx_wr_nxt, tx_rd_nxt;
  logic rx_empty, rx_full, tx_empty, tx_full;
  logic accept, size_ok, is_data, is_status, is_halt;
  logic rx_push, rx_pop, tx_push, tx_drain;
  logic [7:0] rx_rdata, tx_rdata;

  assign rx_wr_nxt = (rx_wr_q == RxLast) ? '0 : rx_wr_q + 1'b1;
  assign rx_rd_nxt = (rx_rd_q == RxLast) ? '0 : rx_rd_q + 1'b1;
  assign tx_wr_nxt = (tx_wr_q == TxLast) ? '0 : tx_wr_q + 1'b1;
  assign tx_rd_nxt = (tx_rd_q == TxLast) ? '0 : tx_rd_q + 1'b1;

  assign rx_empty = (rx_rd_q == rx_wr_q);
  assign rx_full  = (rx_wr_nxt == rx_rd_q);
  assign tx_empty = (tx_rd_q == tx_wr_q);
  assign tx_full  = (tx_wr_nxt == tx_rd_q);

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  assign size_ok   = (in_data_i.access_size == SIZE_BYTE);
  assign is_data   = size_ok && (in_data_i.address == ADDR_DATA);
  assign is_status = size_ok && (in_data_i.address == ADDR_STATUS);
  assign is_halt   = in_data_i.host_valid && (in_data_i.host_byte == HALT_BYTE);

  // decode one transaction against the current pointers
  always_comb begin
    pend_d  = '0;
    rx_push = 1'b0;
    rx_pop  = 1'b0;
    tx_push = 1'b0;
    tx_drain = 1'b0;
    unique case (in_data_i.mode)
      MODE_READ: begin
        if (is_data) begin
          rx_pop     = !rx_empty;
          pend_d.err = rx_empty;
        end else if (is_status) begin
          pend_d.status[STAT_RX_AVAIL_BIT] = !rx_empty;
          pend_d.status[STAT_TX_FULL_BIT]  = tx_full;
        end else begin
          pend_d.err = 1'b1;
        end
      end
      MODE_WRITE: begin
        if (is_data) begin
          tx_push    = !tx_full;
          pend_d.err = tx_full;
        end else if (!is_status) begin
          pend_d.err = 1'b1;
        end
      end
      MODE_TICK: begin
        if (is_halt) begin
          pend_d.halt = 1'b1;
        end else begin
          rx_push  = in_data_i.host_valid && !rx_full;
          tx_drain = !tx_empty;
        end
      end
      default: begin
      end
    endcase
    pend_d.rx_pop   = rx_pop;
    pend_d.tx_drain = tx_drain;
  end

  // pointers advance at accept; reads and writes of one transaction never
  // touch the same entry, and any later read comes at a later edge than the write
  always_comb begin
    rx_wr_d = rx_wr_q;
    rx_rd_d = rx_rd_q;
    tx_wr_d = tx_wr_q;
    tx_rd_d = tx_rd_q;
    if (accept) begin
      if (rx_push)  rx_wr_d = rx_wr_nxt;
      if (rx_pop)   rx_rd_d = rx_rd_nxt;
      if (tx_push)  tx_wr_d = tx_wr_nxt;
      if (tx_drain) tx_rd_d = tx_rd_nxt;
    end
  end

  uartfb_ram #(
    .Width(8),
    .Depth(RxDepth)
  ) u_rx_ram (
    .clk_i  (clk_i),
    .we_i   (accept && rx_push),
    .waddr_i(rx_wr_q),
    .wdata_i(in_data_i.host_byte),
    .re_i   (accept && rx_pop),
    .raddr_i(rx_rd_q),
    .rdata_o(rx_rdata)
  );

  uartfb_ram #(
    .Width(8),
    .Depth(TxDepth)
  ) u_tx_ram (
    .clk_i  (clk_i),
    .we_i   (accept && tx_push),
    .waddr_i(tx_wr_q),
    .wdata_i(in_data_i.write_data),
    .re_i   (accept && tx_drain),
    .raddr_i(tx_rd_q),
    .rdata_o(tx_rdata)
  );

  // sequencer: accept, then merge RAM data into the output register
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.read_data    = pend_q.rx_pop ? rx_rdata : pend_q.status;
          out_d.access_error = pend_q.err;
          out_d.line_valid   = pend_q.tx_drain;
          out_d.line_byte    = pend_q.tx_drain ? tx_rdata : 8'h00;
          out_d.halt_request = pend_q.halt;
          out_valid_d        = 1'b1;
          state_d            = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      rx_wr_q     <= '0;
      rx_rd_q     <= '0;
      tx_wr_q     <= '0;
      tx_rd_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      rx_wr_q     <= rx_wr_d;
      rx_rd_q     <= rx_rd_d;
      tx_wr_q     <= tx_wr_d;
      tx_rd_q     <= tx_rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_q <= pend_d;
    end
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // accepted transaction always moves the sequencer to the RAM read cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_READ))
    else $error("accepted transaction did not start a read cycle");

  // a transaction pops the receive FIFO or drains the transmit FIFO, never both
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> !(pend_q.rx_pop && pend_q.tx_drain))
    else $error("pop and drain pending together");

  // a halt tick neither drains nor reports bus data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.halt_request) |->
      (!out_data_o.line_valid && (out_data_o.read_data == 8'h00)))
    else $error("halt result carries data");

  // failed access returns zero data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.access_error) |-> (out_data_o.read_data == 8'h00))
    else $error("error result carries data");

  // the pointer-equal empty test must never see an overfilled FIFO
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && rx_push) |=> (rx_wr_q != rx_rd_q))
    else $error("receive push left FIFO looking empty");

endmodule

FILE: rtl/uartfb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uartfb_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module uartfb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read data holds until the next read
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: verif/uart_fifo_bus_device_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_fifo_bus_device_core_tb
// Drives bus reads, bus writes and line ticks into the UART FIFO core with
// random idling on both channels. Every result is compared field by field
// with a fixed expected response or with an in-order model of the receive and transmit ring FIFOs.
// ----------------------------------------------------------------------------
module uart_fifo_bus_device_core_tb;
  import uartfb_pkg::*;

  localparam int unsigned RX_SLOTS = RxDepthDefault;
  localparam int unsigned TX_SLOTS = TxDepthDefault;
  localparam logic [1:0]  MODE_UNUSED = 2'd3;
  localparam int unsigned SEG_LEN = 50;
  localparam int unsigned SEG_COUNT = 28;

  localparam rsp_t RSP_NONE = '0;
  localparam rsp_t RSP_ERR  = rsp_t'{access_error: 1'b1, default: '0};
  localparam rsp_t RSP_HALT = rsp_t'{halt_request: 1'b1, default: '0};

  typedef enum int unsigned {
    LEAN_MIXED,
    LEAN_TX_FILL,
    LEAN_RX_FILL,
    LEAN_DRAIN
  } lean_e;

  typedef struct packed {
    req_t req;
    logic has_fixed;
    rsp_t rsp;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req_data = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp_data;

  // model state
  logic [7:0]  rx_mem [RX_SLOTS];
  logic [7:0]  tx_mem [TX_SLOTS];
  int unsigned rx_wr_ptr = 0, rx_rd_ptr = 0, tx_wr_ptr = 0, tx_rd_ptr = 0;

  rsp_t        uart_expected [$];
  int unsigned fail_count = 0;
  int unsigned n_sent = 0, n_checked = 0;
  int unsigned n_pops = 0, n_pushes = 0, n_drains = 0, n_halts = 0;
  int unsigned n_errors = 0, n_tx_full = 0, n_rx_drops = 0;
  logic        calm = 1'b0;
  int unsigned stall_left = 0;

  uart_fifo_bus_device_core u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (req_valid),
    .in_stall_o (req_stall),
    .in_data_i  (req_data),
    .out_valid_o(rsp_valid),
    .out_stall_i(rsp_stall),
    .out_data_o (rsp_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic int unsigned next_slot(int unsigned p, int unsigned depth);
    return (p + 1 >= depth) ? 0 : p + 1;
  endfunction

  function automatic rsp_t uart_predict(req_t r);
    rsp_t o;
    logic reg_ok;
    o = '0;
    reg_ok = (r.access_size == SIZE_BYTE);
    case (r.mode)
      MODE_READ: begin
        if (reg_ok && r.address == ADDR_DATA) begin
          if (rx_wr_ptr != rx_rd_ptr) begin
            o.read_data = rx_mem[rx_rd_ptr];
            rx_rd_ptr = next_slot(rx_rd_ptr, RX_SLOTS);
            n_pops++;
          end else begin
            o.access_error = 1'b1;
          end
        end else if (reg_ok && r.address == ADDR_STATUS) begin
          o.read_data[STAT_RX_AVAIL_BIT] = (rx_wr_ptr != rx_rd_ptr);
          o.read_data[STAT_TX_FULL_BIT]  = (next_slot(tx_wr_ptr, TX_SLOTS) == tx_rd_ptr);
        end else begin
          o.access_error = 1'b1;
        end
      end
      MODE_WRITE: begin
        if (reg_ok && r.address == ADDR_DATA) begin
          if (next_slot(tx_wr_ptr, TX_SLOTS) != tx_rd_ptr) begin
            tx_mem[tx_wr_ptr] = r.write_data;
            tx_wr_ptr = next_slot(tx_wr_ptr, TX_SLOTS);
            n_pushes++;
          end else begin
            o.access_error = 1'b1;
            n_tx_full++;
          end
        end else if (!(reg_ok && r.address == ADDR_STATUS)) begin
          o.access_error = 1'b1;
        end
      end
      MODE_TICK: begin
        if (r.host_valid && r.host_byte == HALT_BYTE) begin
          o.halt_request = 1'b1;
          n_halts++;
        end else begin
          if (r.host_valid) begin
            if (next_slot(rx_wr_ptr, RX_SLOTS) != rx_rd_ptr) begin
              rx_mem[rx_wr_ptr] = r.host_byte;
              rx_wr_ptr = next_slot(rx_wr_ptr, RX_SLOTS);
            end else begin
              n_rx_drops++;
            end
          end
          if (tx_wr_ptr != tx_rd_ptr) begin
            o.line_valid = 1'b1;
            o.line_byte  = tx_mem[tx_rd_ptr];
            tx_rd_ptr = next_slot(tx_rd_ptr, TX_SLOTS);
            n_drains++;
          end
        end
      end
      default: ;
    endcase
    if (o.access_error) n_errors++;
    return o;
  endfunction

  function automatic req_t mk_req(logic [1:0] mode, logic [31:0] addr, logic [3:0] size,
                                  logic [7:0] wdata, logic hvalid, logic [7:0] hbyte);
    req_t r;
    r.mode        = mode;
    r.address     = addr;
    r.access_size = size;
    r.write_data  = wdata;
    r.host_valid  = hvalid;
    r.host_byte   = hbyte;
    return r;
  endfunction

  function automatic req_t pick_req(lean_e lean);
    req_t r;
    int unsigned roll;
    r.write_data  = 8'($urandom);
    r.host_byte   = ($urandom_range(0, 15) == 0) ? HALT_BYTE : 8'($urandom);
    r.host_valid  = 1'($urandom_range(0, 1));
    r.access_size = SIZE_BYTE;
    r.address     = ($urandom_range(0, 3) == 0) ? ADDR_STATUS : ADDR_DATA;
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      // malformed: any mode, stray address, any size
      r.mode        = 2'($urandom_range(0, 3));
      r.address     = $urandom_range(0, 1) ? 32'($urandom) : 32'($urandom_range(0, 3));
      r.access_size = 4'($urandom_range(0, 15));
      return r;
    end
    case (lean)
      LEAN_TX_FILL: r.mode = (roll < 75) ? MODE_WRITE : (roll < 90) ? MODE_TICK : MODE_READ;
      LEAN_RX_FILL: begin
        r.mode = (roll < 70) ? MODE_TICK : (roll < 85) ? MODE_WRITE : MODE_READ;
        if (r.mode == MODE_TICK && roll < 65) r.host_valid = 1'b1;
      end
      LEAN_DRAIN: begin
        r.mode = (roll < 55) ? MODE_READ : MODE_TICK;
        if (roll < 85) r.host_valid = 1'b0;
      end
      default: r.mode = (roll < 40) ? MODE_READ : (roll < 70) ? MODE_WRITE : MODE_TICK;
    endcase
    return r;
  endfunction

  task automatic send(req_t r, logic has_fixed, rsp_t fixed);
    rsp_t p;
    if (!calm && $urandom_range(0, 5) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    p = uart_predict(r);
    uart_expected.push_back(has_fixed ? fixed : p);
    n_sent++;
  endtask

  task automatic drain_wait();
    req_valid <= 1'b0;
    while (uart_expected.size() != 0) @(posedge clk);
  endtask

  // receiver stall bursts, started at random while not calm
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      rsp_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 9);
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    rsp_t want;
    if (rst_n && rsp_valid && !rsp_stall) begin
      if (uart_expected.size() == 0) begin
        $error("unexpected result %h", rsp_data);
        fail_count++;
      end else begin
        want = uart_expected.pop_front();
        n_checked++;
        if (rsp_data.read_data !== want.read_data) begin
          $error("read_data: expected %h, got %h", want.read_data, rsp_data.read_data);
          fail_count++;
        end
        if (rsp_data.access_error !== want.access_error) begin
          $error("access_error: expected %b, got %b", want.access_error,
                 rsp_data.access_error);
          fail_count++;
        end
        if (rsp_data.line_valid !== want.line_valid) begin
          $error("line_valid: expected %b, got %b", want.line_valid, rsp_data.line_valid);
          fail_count++;
        end
        if (rsp_data.line_byte !== want.line_byte) begin
          $error("line_byte: expected %h, got %h", want.line_byte, rsp_data.line_byte);
          fail_count++;
        end
        if (rsp_data.halt_request !== want.halt_request) begin
          $error("halt_request: expected %b, got %b", want.halt_request,
                 rsp_data.halt_request);
          fail_count++;
        end
      end
    end
  end

  initial begin
    row_t  plan [$];
    lean_e lean;
    plan.push_back('{mk_req(MODE_READ, ADDR_STATUS, SIZE_BYTE, 8'h00, 1'b0, 8'h00), 1'b1, RSP_NONE});
    plan.push_back('{mk_req(MODE_READ, ADDR_DATA, SIZE_BYTE, 8'hff, 1'b1, 8'hff), 1'b1, RSP_ERR});
    plan.push_back('{mk_req(MODE_READ, 32'd2, SIZE_BYTE, 8'h00, 1'b0, 8'h00), 1'b1, RSP_ERR});
    plan.push_back('{mk_req(MODE_READ, ADDR_DATA, 4'd0, 8'h00, 1'b0, 8'h00), 1'b1, RSP_ERR});
    plan.push_back('{mk_req(MODE_WRITE, ADDR_DATA, 4'hf, 8'h5a, 1'b0, 8'h00), 1'b1, RSP_ERR});
    plan.push_back('{mk_req(MODE_WRITE, 32'hffff_ffff, SIZE_BYTE, 8'h11, 1'b0, 8'h00), 1'b1,
                     RSP_ERR});
    plan.push_back('{mk_req(MODE_WRITE, ADDR_STATUS, SIZE_BYTE, 8'hff, 1'b1, 8'h17), 1'b1,
                     RSP_NONE});
    plan.push_back('{mk_req(MODE_UNUSED, ADDR_DATA, SIZE_BYTE, 8'hff, 1'b1, 8'hff), 1'b1,
                     RSP_NONE});
    plan.push_back('{mk_req(MODE_TICK, ADDR_DATA, SIZE_BYTE, 8'h00, 1'b0, 8'h00), 1'b1, RSP_NONE});
    plan.push_back('{mk_req(MODE_TICK, ADDR_DATA, SIZE_BYTE, 8'h00, 1'b1, HALT_BYTE), 1'b1,
                     RSP_HALT});
    plan.push_back('{mk_req(MODE_TICK, 32'hffff_ffff, 4'hf, 8'hff, 1'b1, 8'hff), 1'b1, RSP_NONE});
    // halt byte without host_valid is no halt
    plan.push_back('{mk_req(MODE_TICK, ADDR_DATA, SIZE_BYTE, 8'h00, 1'b0, HALT_BYTE), 1'b1,
                     RSP_NONE});
    plan.push_back('{mk_req(MODE_WRITE, ADDR_DATA, SIZE_BYTE, 8'hff, 1'b0, 8'h00), 1'b1, RSP_NONE});
    plan.push_back('{mk_req(MODE_WRITE, ADDR_DATA, SIZE_BYTE, 8'h00, 1'b1, 8'hff), 1'b1, RSP_NONE});
    plan.push_back('{mk_req(MODE_READ, ADDR_STATUS, SIZE_BYTE, 8'h00, 1'b0, 8'h00), 1'b0, RSP_NONE});
    plan.push_back('{mk_req(MODE_READ, ADDR_DATA, SIZE_BYTE, 8'h00, 1'b0, 8'h00), 1'b0, RSP_NONE});
    // halt with bytes queued for transmit: no drain on this tick
    plan.push_back('{mk_req(MODE_TICK, ADDR_DATA, SIZE_BYTE, 8'h00, 1'b1, HALT_BYTE), 1'b1,
                     RSP_HALT});
    plan.push_back('{mk_req(MODE_TICK, ADDR_DATA, SIZE_BYTE, 8'h00, 1'b1, 8'h00), 1'b0, RSP_NONE});
    plan.push_back('{mk_req(MODE_TICK, ADDR_DATA, SIZE_BYTE, 8'h00, 1'b0, 8'h00), 1'b0, RSP_NONE});
    plan.push_back('{mk_req(MODE_TICK, ADDR_DATA, SIZE_BYTE, 8'h00, 1'b0, 8'h00), 1'b0, RSP_NONE});
    plan.push_back('{mk_req(MODE_READ, ADDR_DATA, SIZE_BYTE, 8'h00, 1'b0, 8'h00), 1'b0, RSP_NONE});
    plan.push_back('{mk_req(MODE_READ, ADDR_DATA, SIZE_BYTE, 8'h00, 1'b0, 8'h00), 1'b0, RSP_NONE});
    plan.push_back('{mk_req(MODE_READ, 32'h8000_0000, SIZE_BYTE, 8'h00, 1'b0, 8'h00), 1'b1,
                     RSP_ERR});
    plan.push_back('{mk_req(MODE_READ, ADDR_STATUS, 4'hf, 8'h00, 1'b0, 8'h00), 1'b1, RSP_ERR});

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) send(plan[i].req, plan[i].has_fixed, plan[i].rsp);
    drain_wait();

    for (int unsigned seg = 0; seg < SEG_COUNT; seg++) begin
      lean = lean_e'($urandom_range(0, 3));
      // last segments run without any idling
      calm <= (seg >= SEG_COUNT - 4) || ($urandom_range(0, 4) == 0);
      if (seg == SEG_COUNT / 2) drain_wait();
      for (int unsigned k = 0; k < SEG_LEN; k++) send(pick_req(lean), 1'b0, RSP_NONE);
    end
    drain_wait();
    repeat (10) @(posedge clk);

    $display("%0d transactions sent, %0d results checked", n_sent, n_checked);
    $display("%0d pops, %0d tx pushes, %0d drains, %0d halts, %0d bus errors",
             n_pops, n_pushes, n_drains, n_halts, n_errors);
    $display("%0d tx full rejects, %0d rx drops", n_tx_full, n_rx_drops);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
